>>> rtl/core/software_timer_bank_top_defines.svh
// ----------------------------------------------------------------------------
// software timer bank assertion macros
// checks on the sequencer and result path, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH

`ifndef SYNTH
`define STB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stb check failed");
`define STB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stb check failed");
`else
`define STB_ASSERT_SAME(label, ante, cons)
`define STB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/stb_pkg.sv
// ----------------------------------------------------------------------------
// software timer bank package
// shared constants, command and status codes, timer entry type
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS = 64;
    localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_SWEEP    = 3'd1;
    localparam logic [2:0] CMD_START    = 3'd2;
    localparam logic [2:0] CMD_STOP     = 3'd3;
    localparam logic [2:0] CMD_SET_DUR  = 3'd4;
    localparam logic [2:0] CMD_QUERY    = 3'd5;

    localparam logic [1:0] STAT_HALTED  = 2'd0;
    localparam logic [1:0] STAT_STARTED = 2'd1;
    localparam logic [1:0] STAT_RUNNING = 2'd2;
    localparam logic [1:0] STAT_ELAPSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] start;
        logic [15:0] duration;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/core/stb_ram.sv
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/stb_timer_unit.sv
// ----------------------------------------------------------------------------
// timer update unit
// shared elapsed subtractor, duration compare, status, start and duration update
// ----------------------------------------------------------------------------
module stb_timer_unit (
    input  stb_pkg::entry_t cur,
    input  logic [15:0]     tick,
    input  logic [2:0]      op,
    input  logic [15:0]     new_duration,
    output stb_pkg::entry_t upd,
    output logic            upd_we,
    output logic [15:0]     gone
);

    import stb_pkg::*;

    always_comb
    begin
        gone   = tick - cur.start;
        upd    = cur;
        upd_we = 1'b0;
        case (op)
            CMD_SWEEP:
            begin
                if (cur.status == STAT_RUNNING)
                begin
                    upd_we = 1'b1;
                    if (gone >= cur.duration)
                    begin
                        upd.status = STAT_ELAPSED;
                    end
                end
                else if (cur.status == STAT_STARTED)
                begin
                    upd_we     = 1'b1;
                    upd.start  = tick;
                    upd.status = STAT_RUNNING;
                end
            end
            CMD_START:
            begin
                upd_we     = 1'b1;
                upd.status = STAT_STARTED;
            end
            CMD_STOP:
            begin
                upd_we     = 1'b1;
                upd.status = STAT_HALTED;
            end
            CMD_SET_DUR:
            begin
                upd_we       = 1'b1;
                upd.duration = new_duration;
            end
            default:
            begin
                upd_we = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/software_timer_bank_top.sv
// ----------------------------------------------------------------------------
// software timer bank top
// one result item per command item, sweep every timer through one ram port
// flow: tick, start, stop, set duration, query go through S_RD and S_MOD to the registered result
// sweep: S_SW_RD and S_SW_WR for each timer on the ram, then S_RD and S_MOD for the addressed one
// a new command is taken only in S_IDLE, after the last result is written; S_MOD waits on result stalls
// reset: control, tick counter and entry valid flags clear at once, no sweep
// ----------------------------------------------------------------------------
`include "software_timer_bank_top_defines.svh"

module software_timer_bank_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [7:0]  timer_index,
    input  logic [15:0] duration_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        not_running,
    output logic [15:0] elapsed_ticks,
    output logic        index_valid
);

    import stb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SW_RD = 3'd1;
    localparam logic [2:0] S_SW_WR = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;

    localparam logic [ADDR_W-1:0] LAST_TIMER = ADDR_W'(NUM_TIMERS - 1);

    logic [2:0]            state_reg, state_next;
    logic [15:0]           tick_reg, tick_next;
    logic [ADDR_W-1:0]     sweep_cnt_reg, sweep_cnt_next;
    logic [2:0]            cmd_reg, cmd_next;
    logic [7:0]            idx_reg, idx_next;
    logic [15:0]           dur_reg, dur_next;
    logic [NUM_TIMERS-1:0] valid_reg, valid_next;
    logic                  rd_valid_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg, status_next;
    logic                  not_running_reg, not_running_next;
    logic [15:0]           elapsed_reg, elapsed_next;
    logic                  index_valid_reg, index_valid_next;

    logic                  idx_ok;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ADDR_W-1:0]     ram_waddr;
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                cur_entry;
    entry_t                upd_entry;
    logic                  upd_we;
    logic [15:0]           gone;
    logic [2:0]            unit_op;
    logic                  out_free;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign not_running   = not_running_reg;
    assign elapsed_ticks = elapsed_reg;
    assign index_valid   = index_valid_reg;

    assign idx_ok    = ({1'b0, idx_reg} < 9'(NUM_TIMERS));
    assign out_free  = !out_valid_reg || out_ready;
    assign ram_raddr = (state_reg == S_SW_RD) ? sweep_cnt_reg : idx_reg[ADDR_W-1:0];
    assign ram_waddr = (state_reg == S_SW_WR) ? sweep_cnt_reg : idx_reg[ADDR_W-1:0];
    assign cur_entry = rd_valid_reg ? entry_t'(ram_rdata) : entry_t'('0);
    // after the sweep pass the addressed timer is only reported
    assign unit_op   = (state_reg == S_SW_WR) ? CMD_SWEEP :
                       (cmd_reg == CMD_SWEEP) ? CMD_QUERY : cmd_reg;

    stb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENTRY_W'(upd_entry)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stb_timer_unit u_unit (
        .cur          (cur_entry),
        .tick         (tick_reg),
        .op           (unit_op),
        .new_duration (dur_reg),
        .upd          (upd_entry),
        .upd_we       (upd_we),
        .gone         (gone)
    );

    always_comb
    begin
        state_next       = state_reg;
        tick_next        = tick_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        dur_next         = dur_reg;
        valid_next       = valid_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        not_running_next = not_running_reg;
        elapsed_next     = elapsed_reg;
        index_valid_next = index_valid_reg;
        ram_we           = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = cmd;
                    idx_next       = timer_index;
                    dur_next       = duration_ticks;
                    sweep_cnt_next = '0;
                    if (cmd == CMD_TICK)
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                    state_next = (cmd == CMD_SWEEP) ? S_SW_RD : S_RD;
                end
            end
            S_SW_RD:
            begin
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                ram_we = upd_we;
                if (upd_we)
                begin
                    valid_next[sweep_cnt_reg] = 1'b1;
                end
                if (sweep_cnt_reg == LAST_TIMER)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                    state_next     = S_SW_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (out_free)
                begin
                    ram_we = upd_we && idx_ok;
                    if (upd_we && idx_ok)
                    begin
                        valid_next[idx_reg[ADDR_W-1:0]] = 1'b1;
                    end
                    out_valid_next   = 1'b1;
                    index_valid_next = idx_ok;
                    status_next      = idx_ok ? upd_entry.status : STAT_HALTED;
                    not_running_next = idx_ok && (upd_entry.status == STAT_HALTED);
                    elapsed_next     = idx_ok ? gone : 16'd0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            sweep_cnt_reg <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            sweep_cnt_reg <= sweep_cnt_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= valid_reg[ram_raddr];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        idx_reg         <= idx_next;
        dur_reg         <= dur_next;
        status_reg      <= status_next;
        not_running_reg <= not_running_next;
        elapsed_reg     <= elapsed_next;
        index_valid_reg <= index_valid_next;
    end

    `STB_ASSERT_SAME(a_we_state, ram_we, (state_reg == S_SW_WR) || (state_reg == S_MOD))
    `STB_ASSERT_NEXT(a_sweep_step, (state_reg == S_SW_WR) && (sweep_cnt_reg != LAST_TIMER), state_reg == S_SW_RD)
    `STB_ASSERT_SAME(a_invalid_zero, out_valid && !index_valid, (status == STAT_HALTED) && !not_running && (elapsed_ticks == 16'd0))
    `STB_ASSERT_NEXT(a_tick_inc, in_valid && in_ready && (cmd == CMD_TICK), tick_reg == $past(tick_reg) + 16'd1)

endmodule
